@@ hdl/fsba_pkg.sv @@
package fsba_pkg;

   localparam int MaxSegments = 64;
   localparam int IdxW        = 6;
   localparam int CntW        = 7;
   localparam int SizeW       = 13;
   localparam int AddrW       = 12;
   localparam int PoolLimit   = 4096;
   localparam int EntryW      = AddrW + SizeW + 1;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_NOTFND  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NEXT  = 2'd3
   } fit_type;

   localparam logic CSR_FIT  = 1'b0;
   localparam logic CSR_POOL = 1'b1;

   typedef struct packed {
      logic [1:0]       action;
      logic [SizeW-1:0] request_bytes;
      logic [AddrW-1:0] block_start;
      logic [SizeW-1:0] small_limit;
   } req_word_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [AddrW-1:0] granted_start;
      logic [CntW-1:0]  hole_count;
      logic [SizeW-1:0] allocated_bytes;
      logic [SizeW-1:0] free_bytes;
      logic [SizeW-1:0] largest_free;
      logic [CntW-1:0]  small_free_count;
   } rsp_word_type;

   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [SizeW-1:0] size;
      logic             alloc;
   } seg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT_UP,
      S_SPLIT,
      S_MERGE_RD,
      S_MERGE,
      S_SHIFT_DN,
      S_STAT,
      S_OUT,
      S_INIT
   } state_type;

endpackage

@@ hdl/fsba_ram.sv @@
module fsba_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/fit_strategy_block_allocator_unit.sv @@
// Segment allocator for a byte pool of up to 4096 bytes, kept as an
// address-ordered table of up to 64 segments in a single-port-read RAM.
// req_ channel takes one word: allocate, free, status query or clear.
// rsp_ channel returns one word per request: status, granted start and
// pool statistics taken after the action.
// csr_ port writes fit_strategy (index 0) and pool_bytes (index 1) at any
// edge with csr_write_enable high; write only while idle.
// Table reads use the RAM's single read port, at most one per cycle. An
// allocate or free takes a search pass, a decision step, an optional shift
// pass (a read and then a write per moved entry, for a split or a merge) and
// a statistics pass over all segments; a query takes only the statistics
// pass, and a clear rewrites the table as one free segment before it.
// One request at a time; req_ready is low from acceptance until the response
// is taken.
// Reset: the table becomes one free segment of 4096 bytes, rover at 0; this
// is done in S_INIT after reset and produces no response word.
// A stalled receiver holds the response in the output register.
module fit_strategy_block_allocator_unit
   import fsba_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_write_enable,
   input  logic         csr_index,
   input  logic [12:0]  csr_write_data
);

   state_type        state_ff, state_in;
   req_word_type     req_ff, req_in;
   logic [1:0]       fit_ff, fit_in;
   logic [SizeW-1:0] pool_ff, pool_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [IdxW-1:0]  rover_ff, rover_in;
   // scan position, counted reads and a valid flag for the registered RAM data
   logic [CntW-1:0]  pos_ff, pos_in;
   logic [CntW-1:0]  n_ff, n_in;
   logic [IdxW-1:0]  rd_idx_ff, rd_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             pick_ok_ff, pick_ok_in;
   logic [IdxW-1:0]  pick_ff, pick_in;
   seg_type          pseg_ff, pseg_in;
   seg_type          prev_ff, prev_in;
   logic             prev_ok_ff, prev_ok_in;
   logic [1:0]       status_ff, status_in;
   logic [AddrW-1:0] grant_ff, grant_in;
   logic [CntW-1:0]  holes_ff, holes_in;
   logic [SizeW-1:0] used_ff, used_in;
   logic [SizeW-1:0] freeb_ff, freeb_in;
   logic [SizeW-1:0] large_ff, large_in;
   logic [CntW-1:0]  small_ff, small_in;
   logic             mstep_ff, mstep_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [IdxW-1:0]  wr_addr, rd_addr;
   seg_type          wr_data, rd_data;
   logic [SizeW-1:0] eff_pool;

   fsba_ram #(.Width(EntryW), .Depth(MaxSegments)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = '{status: status_ff, granted_start: grant_ff, hole_count: holes_ff,
                        allocated_bytes: used_ff, free_bytes: freeb_ff,
                        largest_free: large_ff, small_free_count: small_ff};

   always_comb begin
      if (pool_ff == '0) begin
         eff_pool = SizeW'(1);
      end else if (pool_ff > SizeW'(PoolLimit)) begin
         eff_pool = SizeW'(PoolLimit);
      end else begin
         eff_pool = pool_ff;
      end
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         fit_ff       <= FIT_FIRST;
         pool_ff      <= SizeW'(PoolLimit);
         count_ff     <= CntW'(1);
         rover_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         req_ff       <= '{action: ACT_CLEAR, default: '0};
      end else begin
         state_ff     <= state_in;
         fit_ff       <= fit_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         rover_ff     <= rover_in;
         rsp_valid_ff <= rsp_valid_in;
         req_ff       <= req_in;
      end
      pos_ff     <= pos_in;
      n_ff       <= n_in;
      rd_idx_ff  <= rd_idx_in;
      rd_vld_ff  <= rd_vld_in;
      pick_ok_ff <= pick_ok_in;
      pick_ff    <= pick_in;
      pseg_ff    <= pseg_in;
      prev_ff    <= prev_in;
      prev_ok_ff <= prev_ok_in;
      status_ff  <= status_in;
      grant_ff   <= grant_in;
      holes_ff   <= holes_in;
      used_ff    <= used_in;
      freeb_ff   <= freeb_in;
      large_ff   <= large_in;
      small_ff   <= small_in;
      mstep_ff   <= mstep_in;
   end

   // sequencer: at most one RAM read per cycle, data checked in the next cycle
   always_comb begin
      logic             fitok;
      logic             better;
      logic [CntW-1:0]  idx_c;
      logic [IdxW-1:0]  first;
      seg_type          s;
      state_in     = state_ff;
      req_in       = req_ff;
      fit_in       = fit_ff;
      pool_in      = pool_ff;
      count_in     = count_ff;
      rover_in     = rover_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      pick_ok_in   = pick_ok_ff;
      pick_in      = pick_ff;
      pseg_in      = pseg_ff;
      prev_in      = prev_ff;
      prev_ok_in   = prev_ok_ff;
      status_in    = status_ff;
      grant_in     = grant_ff;
      holes_in     = holes_ff;
      used_in      = used_ff;
      freeb_in     = freeb_ff;
      large_in     = large_ff;
      small_in     = small_ff;
      mstep_in     = mstep_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;
      s            = rd_data;
      fitok        = !s.alloc && (s.size >= req_ff.request_bytes);
      better       = 1'b0;
      idx_c        = '0;
      first        = (CntW'(rover_ff) < count_ff) ? rover_ff : '0;

      if (csr_write_enable) begin
         if (csr_index == CSR_FIT) begin
            fit_in = csr_write_data[1:0];
         end else begin
            pool_in = csr_write_data;
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in     = req_data;
               pos_in     = '0;
               n_in       = '0;
               pick_ok_in = 1'b0;
               prev_ok_in = 1'b0;
               status_in  = ST_OK;
               grant_in   = '0;
               state_in   = S_OUT;
               if (req_data.action == ACT_ALLOC || req_data.action == ACT_FREE) begin
                  state_in = S_SCAN;
               end else if (req_data.action == ACT_QUERY) begin
                  state_in = S_STAT;
               end
            end
         end
         // search pass for a fit or for the address to free
         S_SCAN: begin
            if (n_ff < count_ff) begin
               if (req_ff.action == ACT_ALLOC && fit_ff == FIT_NEXT) begin
                  idx_c = CntW'(first) + n_ff;
                  if (idx_c >= count_ff) idx_c = idx_c - count_ff;
               end else begin
                  idx_c = n_ff;
               end
               rd_addr   = idx_c[IdxW-1:0];
               rd_idx_in = idx_c[IdxW-1:0];
               rd_vld_in = 1'b1;
               n_in      = n_ff + CntW'(1);
            end
            if (rd_vld_ff) begin
               if (req_ff.action == ACT_ALLOC) begin
                  if (fitok) begin
                     case (fit_ff)
                        FIT_BEST:  better = !pick_ok_ff || (s.size < pseg_ff.size);
                        FIT_WORST: better = !pick_ok_ff || (s.size > pseg_ff.size);
                        default:   better = !pick_ok_ff;
                     endcase
                  end
               end else begin
                  better = !pick_ok_ff && (s.start == req_ff.block_start);
               end
               if (better) begin
                  pick_ok_in = 1'b1;
                  pick_in    = rd_idx_ff;
                  pseg_in    = s;
               end
            end
            if (n_ff >= count_ff && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_STAT;
            if (req_ff.action == ACT_ALLOC) begin
               if (req_ff.request_bytes == '0 || !pick_ok_ff) begin
                  status_in = ST_NOFIT;
               end else if (pseg_ff.size == req_ff.request_bytes) begin
                  wr_en    = 1'b1;
                  wr_addr  = pick_ff;
                  wr_data  = '{start: pseg_ff.start, size: pseg_ff.size, alloc: 1'b1};
                  rover_in = (CntW'(pick_ff) + CntW'(1) >= count_ff) ? '0 : pick_ff + 1'b1;
                  grant_in = pseg_ff.start;
               end else if (count_ff >= CntW'(MaxSegments)) begin
                  status_in = ST_FULL;
               end else begin
                  pos_in   = count_ff;
                  state_in = S_SHIFT_UP;
               end
            end else if (!pick_ok_ff) begin
               status_in = ST_NOTFND;
            end else begin
               // look at left then right neighbor
               mstep_in = 1'b0;
               pos_in   = CntW'(pick_ff);
               state_in = S_MERGE_RD;
            end
         end
         // open a slot after the pick: read k-1, write k
         S_SHIFT_UP: begin
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[IdxW-1:0];
               wr_data = s;
               pos_in  = pos_ff - CntW'(1);
            end
            if (pos_ff > CntW'(pick_ff) + CntW'(1)) begin
               if (!rd_vld_ff) begin
                  rd_addr   = IdxW'(pos_ff - CntW'(1));
                  rd_vld_in = 1'b1;
               end
            end else if (!rd_vld_ff) begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            if (!mstep_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pick_ff + 1'b1;
               wr_data  = '{start: pseg_ff.start + AddrW'(req_ff.request_bytes),
                            size: pseg_ff.size - req_ff.request_bytes, alloc: 1'b0};
               mstep_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pick_ff;
               wr_data  = '{start: pseg_ff.start, size: req_ff.request_bytes, alloc: 1'b1};
               count_in = count_ff + CntW'(1);
               rover_in = pick_ff + 1'b1;
               grant_in = pseg_ff.start;
               mstep_in = 1'b0;
               state_in = S_STAT;
            end
         end
         // fetch neighbors of the freed entry
         S_MERGE_RD: begin
            if (!mstep_ff) begin
               mstep_in = 1'b1;
               if (pick_ff != '0) begin
                  rd_addr   = pick_ff - 1'b1;
                  rd_vld_in = 1'b1;
               end
            end else begin
               if (rd_vld_ff) begin
                  prev_in    = s;
                  prev_ok_in = !s.alloc;
               end
               if (CntW'(pick_ff) + CntW'(1) < count_ff) begin
                  rd_addr   = pick_ff + 1'b1;
                  rd_vld_in = 1'b1;
               end
               mstep_in = 1'b0;
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (!rd_vld_ff && !mstep_ff) begin
               mstep_in = 1'b1;
            end
            if (rd_vld_ff || mstep_ff) begin
               // combine into one entry, then close gaps
               wr_en    = 1'b1;
               mstep_in = 1'b0;
               if (prev_ok_ff) begin
                  wr_addr = pick_ff - 1'b1;
                  wr_data = '{start: prev_ff.start,
                              size: prev_ff.size + pseg_ff.size +
                                    ((rd_vld_ff && !s.alloc) ? s.size : '0),
                              alloc: 1'b0};
               end else begin
                  wr_addr = pick_ff;
                  wr_data = '{start: pseg_ff.start,
                              size: pseg_ff.size +
                                    ((rd_vld_ff && !s.alloc) ? s.size : '0),
                              alloc: 1'b0};
               end
               // entries to drop: pick if merged left, next if merged right
               pos_in   = prev_ok_ff ? CntW'(pick_ff) : CntW'(pick_ff) + CntW'(1);
               n_in     = CntW'(prev_ok_ff) + CntW'(rd_vld_ff && !s.alloc);
               if (prev_ok_ff && rover_ff >= pick_ff && rover_ff != '0) begin
                  rover_in = rover_ff - 1'b1;
               end
               if (rd_vld_ff && !s.alloc) begin
                  if (rover_ff >= pick_ff + 1'b1 && rover_ff != '0) begin
                     rover_in = (prev_ok_ff && rover_ff >= pick_ff && rover_ff != '0)
                                ? rover_ff - 2'd2 : rover_ff - 1'b1;
                  end else if (prev_ok_ff && rover_ff >= pick_ff && rover_ff != '0
                               && rover_ff - 1'b1 >= pick_ff) begin
                     rover_in = rover_ff - 2'd2;
                  end
               end
               state_in = (CntW'(prev_ok_ff) + CntW'(rd_vld_ff && !s.alloc) == '0)
                          ? S_STAT : S_SHIFT_DN;
            end
         end
         // move entries down over the dropped ones: read k+n, write k
         S_SHIFT_DN: begin
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[IdxW-1:0];
               wr_data = s;
               pos_in  = pos_ff + CntW'(1);
            end
            if (pos_ff + n_ff < count_ff) begin
               if (!rd_vld_ff) begin
                  rd_addr   = IdxW'(pos_ff + n_ff);
                  rd_vld_in = 1'b1;
               end
            end else if (!rd_vld_ff) begin
               count_in = count_ff - n_ff;
               state_in = S_STAT;
            end
         end
         // statistics pass over the table
         S_STAT: begin
            if (!mstep_ff) begin
               mstep_in = 1'b1;
               n_in     = '0;
               holes_in = '0;
               used_in  = '0;
               freeb_in = '0;
               large_in = '0;
               small_in = '0;
            end else begin
               if (n_ff < count_ff) begin
                  rd_addr   = n_ff[IdxW-1:0];
                  rd_vld_in = 1'b1;
                  n_in      = n_ff + CntW'(1);
               end
               if (rd_vld_ff) begin
                  if (s.alloc) begin
                     used_in = used_ff + s.size;
                  end else begin
                     holes_in = holes_ff + CntW'(1);
                     freeb_in = freeb_ff + s.size;
                     if (s.size > large_ff) large_in = s.size;
                     if (s.size <= req_ff.small_limit) small_in = small_ff + CntW'(1);
                  end
               end
               if (n_ff >= count_ff && !rd_vld_ff) begin
                  mstep_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         // clear the pool, then report statistics
         S_OUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, size: eff_pool, alloc: 1'b0};
            count_in = CntW'(1);
            rover_in = '0;
            mstep_in = 1'b0;
            state_in = S_STAT;
         end
         // seed the table after reset, no response word
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, size: eff_pool, alloc: 1'b0};
            mstep_in = 1'b0;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // start the step flag clean out of reset
      if (reset) begin
         mstep_in = 1'b0;
      end
   end

endmodule
